[hw/rtl/mpfp_pkg.sv]
// Shared constants and types for the MQTT PUBLISH frame parser.
`default_nettype none

package mpfp_pkg;

    // Parser phase codes
    localparam logic [2:0] PH_HDR   = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_TLHI  = 3'd2;
    localparam logic [2:0] PH_TLLO  = 3'd3;
    localparam logic [2:0] PH_TOPIC = 3'd4;
    localparam logic [2:0] PH_PID   = 3'd5;
    localparam logic [2:0] PH_BODY  = 3'd6;
    localparam logic [2:0] PH_SKIP  = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_TOPIC = 2'd0;
    localparam logic [1:0] KIND_BODY  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // End status codes
    localparam logic [1:0] ST_PUBLISH = 2'd0;
    localparam logic [1:0] ST_OTHER   = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    // Configuration register indexes
    localparam logic CFG_TOPIC_KEEP = 1'b0;
    localparam logic CFG_BODY_KEEP  = 1'b1;

    // Protocol constants
    localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
    localparam logic [1:0] LEN_LAST_BYTE = 2'd3;
    localparam logic [7:0] QOS_MASK      = 8'h06;

    // Reset values of the keep limits
    localparam logic [15:0] TOPIC_KEEP_RST = 16'd255;
    localparam logic [15:0] BODY_KEEP_RST  = 16'd511;

    // Result queue depth
    localparam int          QDEPTH = 4;
    localparam int          QPTR_W = $clog2(QDEPTH);
    localparam int          QCNT_W = $clog2(QDEPTH + 1);

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       part_last;
        logic [1:0] status;
    } result_t;

    // Up to two results pushed per accepted byte, data result first
    typedef struct packed {
        logic    a_valid;
        result_t a;
        logic    b_valid;
        result_t b;
    } push_t;

endpackage

`default_nettype wire

[hw/rtl/mpfp_parser.sv]
// Byte-at-a-time MQTT packet state machine producing topic, body and end results.
`default_nettype none

module mpfp_parser (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [15:0]      topic_keep,
    input  wire logic [15:0]      body_keep,
    output mpfp_pkg::push_t       push
);
    import mpfp_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  hdr_reg, hdr_next;
    logic [27:0] rem_reg, rem_next;
    logic [1:0]  lcnt_reg, lcnt_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] kept_reg, kept_next;
    logic        mal_reg, mal_next;

    // Next state and results for the byte on offer
    always_comb begin
        logic [27:0] len_add;
        logic [27:0] rem_dec;
        logic        end_part;
        logic        do_after_topic;
        logic        do_body;
        logic        do_skip;
        logic        skip_bad;
        logic        do_finish;
        logic [1:0]  fin_status;

        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        rem_next   = rem_reg;
        lcnt_next  = lcnt_reg;
        tlen_next  = tlen_reg;
        pos_next   = pos_reg;
        kept_next  = kept_reg;
        mal_next   = mal_reg;

        push.a_valid     = 1'b0;
        push.a.kind      = KIND_TOPIC;
        push.a.data      = rx_byte;
        push.a.part_last = 1'b0;
        push.a.status    = ST_PUBLISH;
        push.b_valid     = 1'b0;
        push.b.kind      = KIND_END;
        push.b.data      = 8'd0;
        push.b.part_last = 1'b0;
        push.b.status    = ST_PUBLISH;

        do_after_topic = 1'b0;
        do_body        = 1'b0;
        do_skip        = 1'b0;
        skip_bad       = 1'b0;
        do_finish      = 1'b0;
        fin_status     = ST_PUBLISH;
        end_part       = 1'b0;
        rem_dec        = (rem_reg != 28'd0) ? rem_reg - 28'd1 : rem_reg;

        // Seven bits of the length field, placed by the byte's position
        case (lcnt_reg)
            2'd0:    len_add = {21'd0, rx_byte[6:0]};
            2'd1:    len_add = {14'd0, rx_byte[6:0], 7'd0};
            2'd2:    len_add = {7'd0, rx_byte[6:0], 14'd0};
            default: len_add = {rx_byte[6:0], 21'd0};
        endcase

        case (phase_reg)
            PH_HDR: begin
                hdr_next   = rx_byte;
                rem_next   = 28'd0;
                lcnt_next  = 2'd0;
                mal_next   = 1'b0;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                rem_next = rem_reg + len_add;
                if (rx_byte[7] && (lcnt_reg != LEN_LAST_BYTE)) begin
                    lcnt_next = lcnt_reg + 2'd1;
                end else begin
                    lcnt_next = 2'd0;
                    if (hdr_reg[7:4] != TYPE_PUBLISH) begin
                        do_skip = 1'b1;
                    end else if (rem_next < 28'd2) begin
                        do_skip  = 1'b1;
                        skip_bad = 1'b1;
                    end else begin
                        phase_next = PH_TLHI;
                    end
                end
            end
            PH_TLHI: begin
                tlen_next  = {rx_byte, 8'd0};
                rem_next   = rem_reg - 28'd1;
                phase_next = PH_TLLO;
            end
            PH_TLLO: begin
                tlen_next = {tlen_reg[15:8], rx_byte};
                rem_next  = rem_reg - 28'd1;
                if ({12'd0, tlen_next} > rem_next) begin
                    do_skip  = 1'b1;
                    skip_bad = 1'b1;
                end else if (tlen_next == 16'd0) begin
                    do_after_topic = 1'b1;
                end else begin
                    pos_next   = 16'd0;
                    kept_next  = 16'd0;
                    phase_next = PH_TOPIC;
                end
            end
            PH_TOPIC: begin
                end_part = ({1'b0, pos_reg} + 17'd1) >= {1'b0, tlen_reg};
                if (kept_reg < topic_keep) begin
                    push.a_valid     = 1'b1;
                    push.a.kind      = KIND_TOPIC;
                    push.a.part_last = end_part ||
                        (({1'b0, kept_reg} + 17'd1) == {1'b0, topic_keep});
                    kept_next        = kept_reg + 16'd1;
                end
                rem_next = rem_dec;
                pos_next = pos_reg + 16'd1;
                if (end_part) begin
                    do_after_topic = 1'b1;
                end
            end
            PH_PID: begin
                rem_next = rem_dec;
                if (pos_reg != 16'd0) begin
                    do_body = 1'b1;
                end else begin
                    pos_next = 16'd1;
                end
            end
            PH_BODY: begin
                end_part = (rem_reg <= 28'd1);
                if (kept_reg < body_keep) begin
                    push.a_valid     = 1'b1;
                    push.a.kind      = KIND_BODY;
                    push.a.part_last = end_part ||
                        (({1'b0, kept_reg} + 17'd1) == {1'b0, body_keep});
                    kept_next        = kept_reg + 16'd1;
                end
                rem_next = rem_dec;
                if (end_part) begin
                    do_finish  = 1'b1;
                    fin_status = ST_PUBLISH;
                end
            end
            default: begin
                rem_next = rem_dec;
                if (rem_next == 28'd0) begin
                    do_finish  = 1'b1;
                    fin_status = mal_reg ? ST_BAD : ST_OTHER;
                end
            end
        endcase

        // After the topic: skip the packet id when QoS is above zero
        if (do_after_topic) begin
            if ((hdr_reg & QOS_MASK) != 8'd0) begin
                if (rem_next < 28'd2) begin
                    do_skip  = 1'b1;
                    skip_bad = 1'b1;
                end else begin
                    pos_next   = 16'd0;
                    phase_next = PH_PID;
                end
            end else begin
                do_body = 1'b1;
            end
        end

        // Start of the body, or an immediate end when nothing is left
        if (do_body) begin
            pos_next  = 16'd0;
            kept_next = 16'd0;
            if (rem_next == 28'd0) begin
                do_finish  = 1'b1;
                fin_status = ST_PUBLISH;
            end else begin
                phase_next = PH_BODY;
            end
        end

        // Skip to the packet end, finishing at once when nothing is left
        if (do_skip) begin
            mal_next = skip_bad;
            if (rem_next == 28'd0) begin
                do_finish  = 1'b1;
                fin_status = skip_bad ? ST_BAD : ST_OTHER;
            end else begin
                phase_next = PH_SKIP;
            end
        end

        // Packet end result
        if (do_finish) begin
            push.b_valid  = 1'b1;
            push.b.status = fin_status;
            phase_next    = PH_HDR;
        end

        // Nothing moves without an accepted byte
        if (!fire) begin
            push.a_valid = 1'b0;
            push.b_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR;
            hdr_reg   <= 8'd0;
            rem_reg   <= 28'd0;
            lcnt_reg  <= 2'd0;
            tlen_reg  <= 16'd0;
            pos_reg   <= 16'd0;
            kept_reg  <= 16'd0;
            mal_reg   <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            rem_reg   <= rem_next;
            lcnt_reg  <= lcnt_next;
            tlen_reg  <= tlen_next;
            pos_reg   <= pos_next;
            kept_reg  <= kept_next;
            mal_reg   <= mal_next;
        end
    end

`ifndef SYNTHESIS
    // A data result only comes from the topic or body phases.
    a_data_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        push.a_valid |-> (phase_reg == PH_TOPIC || phase_reg == PH_BODY))
        else $error("data result outside topic or body");

    // Every end result returns the parser to the header phase.
    b_ends_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        push.b_valid |=> (phase_reg == PH_HDR))
        else $error("packet end did not return to header phase");
`endif

endmodule

`default_nettype wire

[hw/rtl/mpfp_out_fifo.sv]
// Small result queue taking up to two results a cycle, giving one when ready.
`default_nettype none

module mpfp_out_fifo (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire mpfp_pkg::push_t  push,
    output logic                  room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mpfp_pkg::result_t     out_item
);
    import mpfp_pkg::*;

    result_t             q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                pop;
    logic [QPTR_W-1:0]   b_addr;

    // Room for two results keeps a full byte's output from overflowing
    assign room      = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = q_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign b_addr    = wr_ptr_reg + QPTR_W'(push.a_valid);

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.a_valid) + QPTR_W'(push.b_valid);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(push.a_valid) + QCNT_W'(push.b_valid)
                      - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage of results; the data result goes ahead of the end result
    always_ff @(posedge aclk) begin
        if (push.a_valid) begin
            q_reg[wr_ptr_reg] <= push.a;
        end
        if (push.b_valid) begin
            q_reg[b_addr] <= push.b;
        end
    end

`ifndef SYNTHESIS
    // Results are only pushed while there is room for a whole byte's output.
    push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.a_valid || push.b_valid) |-> room)
        else $error("result pushed into a full queue");

    // The count tracks the distance between the pointers.
    cnt_matches_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg <= QCNT_W'(QDEPTH)) &&
        (QPTR_W'(cnt_reg) == QPTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("queue count out of step with pointers");
`endif

endmodule

`default_nettype wire

[hw/rtl/mqtt_publish_frame_parser_core.sv]
// Top level of the MQTT PUBLISH frame parser: keep registers, parser and result queue.
//
//  Channel  Direction  Content
//  s_       in         tdata[7:0] rx_byte, one received byte per transaction
//  m_       out        tdata[7:0] data, tdata[9:8] status; tuser[1:0] kind;
//                      tlast part_last
//  cfg_     in         write of topic_keep (index 0) or body_keep (index 1)
//
// One byte is taken per cycle; its results enter a four-entry queue in the same edge.
// A byte that closes a packet may give two results, which leave one at a time.
// s_tready is low while fewer than two queue entries are free; m_tready stalls only that.
// Reset is synchronous and active low; it restores the keep limits to 255 and 511.
`default_nettype none

module mqtt_publish_frame_parser_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] data, [9:8] status, [15:10] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import mpfp_pkg::*;

    logic [15:0] topic_keep_reg;
    logic [15:0] body_keep_reg;
    logic        fire;
    logic        room;
    push_t       push;
    result_t     out_item;

    // Keep limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            topic_keep_reg <= TOPIC_KEEP_RST;
            body_keep_reg  <= BODY_KEEP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TOPIC_KEEP: topic_keep_reg <= cfg_wdata;
                CFG_BODY_KEEP:  body_keep_reg  <= cfg_wdata;
                default:        topic_keep_reg <= topic_keep_reg;
            endcase
        end
    end

    // Input transaction
    assign s_tready = room;
    assign fire     = s_tvalid && room;

    mpfp_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .rx_byte    (s_tdata),
        .topic_keep (topic_keep_reg),
        .body_keep  (body_keep_reg),
        .push       (push)
    );

    mpfp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Result transaction fields
    assign m_tdata = {6'd0, out_item.status, out_item.data};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.part_last;

endmodule

`default_nettype wire
